// ===== rtl/core/srrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrs_pkg
// Shared widths, register codes and the quarter-wave sine table for the
// sine raster row shift block.
// ----------------------------------------------------------------------------
package srrs_pkg;

	localparam int SINE_TABLE_SIZE = 1024;
	localparam int MAX_IMAGE_DIM   = 4096;

	localparam int QTR   = SINE_TABLE_SIZE / 4;
	localparam int K_W   = $clog2(QTR);
	localparam int IDX_W = K_W + 1;
	localparam int PH_W  = K_W + 2;

	localparam int ROW_W    = 13;
	localparam int IN_ROW_W = 12;
	localparam int TIME_W   = 32;
	localparam int HH_W     = 12;
	localparam int PROD_W   = TIME_W + HH_W;
	localparam int WL_W     = 12;
	localparam int PER_W    = 16;
	localparam int DALL_W   = WL_W + PER_W;
	localparam int AMP_W    = 12;
	localparam int TAB_W    = 15;
	localparam int TAB_FRAC = 15;
	localparam int OUT_W    = 13;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE    = 4'd0,
		REG_WAVELENGTH   = 4'd1,
		REG_PERIOD       = 4'd2,
		REG_IMAGE_HEIGHT = 4'd3,
		REG_CLIP_TOP     = 4'd4,
		REG_CLIP_LEFT    = 4'd5,
		REG_CLIP_WIDTH   = 4'd6,
		REG_CLIP_HEIGHT  = 4'd7
	} cfg_reg_t;

	typedef logic [QTR:0][TAB_W-1:0] sine_tab_t;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAB_MAX     = 64'd32767;

	// Horner divisors (2m)(2m+1) as 2^64 reciprocals, rounded up; exact
	// floor quotients for dividends below 2^32.
	localparam logic [127:0] RCP_ONE = 128'd1 << 64;
	localparam logic [127:0] RCP_M1  = RCP_ONE / 128'd6 + 128'd1;
	localparam logic [127:0] RCP_M2  = RCP_ONE / 128'd20 + 128'd1;
	localparam logic [127:0] RCP_M3  = RCP_ONE / 128'd42 + 128'd1;
	localparam logic [127:0] RCP_M4  = RCP_ONE / 128'd72 + 128'd1;
	localparam logic [127:0] RCP_M5  = RCP_ONE / 128'd110 + 128'd1;
	localparam logic [127:0] RCP_M6  = RCP_ONE / 128'd156 + 128'd1;

	// Quarter wave in unsigned Q0.15, sine evaluated in Q30 by a truncating
	// Horner series to degree 13. Built at elaboration only.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t    tab;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  t;
		logic [63:0]  s;
		logic [63:0]  v;
		logic [63:0]  sub;
		logic [127:0] rcp;
		tab = '0;
		for (int j = 0; j <= QTR; j++) begin
			x  = (64'(j) * HALF_PI_Q30) >> K_W;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (int m = 6; m >= 1; m--) begin
				case (m)
					1:       rcp = RCP_M1;
					2:       rcp = RCP_M2;
					3:       rcp = RCP_M3;
					4:       rcp = RCP_M4;
					5:       rcp = RCP_M5;
					6:       rcp = RCP_M6;
					default: rcp = '0;
				endcase
				sub = 64'((128'((x2 * t) >> 30) * rcp) >> 64);
				t   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
			end
			s = (x * t) >> 30;
			v = (s * TAB_MAX + (64'd1 << 29)) >> 30;
			if (v > TAB_MAX) begin
				v = TAB_MAX;
			end
			tab[j] = TAB_W'(v);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

// ===== rtl/core/sine_raster_row_shift.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sine_raster_row_shift
// Row copy plan for a wavy horizontal scroll: wave phase, sine lookup,
// signed shift, source and destination columns and copy count per row.
// ----------------------------------------------------------------------------
// One row request is taken every cycle unless the output stalls, and results
// come out in order, one per request. The pipeline depth is set by the
// 44-step remainder chain that reduces frame_time * (image_height / 2)
// modulo period * wavelength and by the 10-step phase division that
// follows it; both are one compare and subtract per stage. A stall on the
// output holds the whole pipeline. Registers must be written only while
// no request is in flight (not enforced); the write port is always ready.
// ----------------------------------------------------------------------------
module sine_raster_row_shift (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [srrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [srrs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic [srrs_pkg::IN_ROW_W-1:0]        row_index,
	input  wire logic [srrs_pkg::TIME_W-1:0]          frame_time,
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic signed [srrs_pkg::OUT_W-1:0]    shift,
	output      logic [srrs_pkg::OUT_W-1:0]           source_column,
	output      logic [srrs_pkg::OUT_W-1:0]           dest_column,
	output      logic [srrs_pkg::OUT_W-1:0]           copy_count,
	output      logic [srrs_pkg::OUT_W-1:0]           image_row
);

	localparam int ROW_W  = srrs_pkg::ROW_W;
	localparam int PROD_W = srrs_pkg::PROD_W;
	localparam int DALL_W = srrs_pkg::DALL_W;
	localparam int WL_W   = srrs_pkg::WL_W;
	localparam int PER_W  = srrs_pkg::PER_W;
	localparam int PH_W   = srrs_pkg::PH_W;
	localparam int K_W    = srrs_pkg::K_W;
	localparam int IDX_W  = srrs_pkg::IDX_W;
	localparam int TAB_W  = srrs_pkg::TAB_W;
	localparam int AMP_W  = srrs_pkg::AMP_W;
	localparam int OUT_W  = srrs_pkg::OUT_W;
	localparam int MUL_W  = TAB_W + AMP_W;

	// ---------------- configuration registers ----------------
	logic [AMP_W-1:0]  amplitude_q;
	logic [WL_W-1:0]   wavelength_q;
	logic [PER_W-1:0]  period_q;
	logic [12:0]       image_height_q;
	logic [11:0]       clip_top_q;
	logic [11:0]       clip_left_q;
	logic [12:0]       clip_width_q;
	logic [12:0]       clip_height_q;
	logic [DALL_W-1:0] d_all_q;

	logic [WL_W-1:0]   w_eff;
	logic [PER_W-1:0]  p_eff;
	logic [11:0]       half_h;
	logic [OUT_W-1:0]  width_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q    <= '0;
			wavelength_q   <= WL_W'(1);
			period_q       <= PER_W'(1);
			image_height_q <= '0;
			clip_top_q     <= '0;
			clip_left_q    <= '0;
			clip_width_q   <= '0;
			clip_height_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (srrs_pkg::cfg_reg_t'(cfg_index))
				srrs_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data[11:0];
				srrs_pkg::REG_WAVELENGTH:   wavelength_q   <= cfg_data[11:0];
				srrs_pkg::REG_PERIOD:       period_q       <= cfg_data[15:0];
				srrs_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[12:0];
				srrs_pkg::REG_CLIP_TOP:     clip_top_q     <= cfg_data[11:0];
				srrs_pkg::REG_CLIP_LEFT:    clip_left_q    <= cfg_data[11:0];
				srrs_pkg::REG_CLIP_WIDTH:   clip_width_q   <= cfg_data[12:0];
				srrs_pkg::REG_CLIP_HEIGHT:  clip_height_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// zero wavelength or period acts as one
	assign w_eff     = (wavelength_q == '0) ? WL_W'(1) : wavelength_q;
	assign p_eff     = (period_q == '0) ? PER_W'(1) : period_q;
	assign half_h    = image_height_q[12:1];
	assign width_sat = (clip_width_q > OUT_W'(srrs_pkg::MAX_IMAGE_DIM)) ?
		OUT_W'(srrs_pkg::MAX_IMAGE_DIM) : clip_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_all_q <= DALL_W'(1);
		end else begin
			d_all_q <= DALL_W'(p_eff) * DALL_W'(w_eff);
		end
	end

	// ---------------- pipeline control ----------------
	logic adv;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: input capture ----------------
	logic                              v_s1;
	logic [srrs_pkg::IN_ROW_W-1:0]     row_s1;
	logic [srrs_pkg::TIME_W-1:0]       tm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= row_index;
			tm_s1  <= frame_time;
		end
	end

	// ---------------- remainder chain ----------------
	// entry 0: absolute row and time product; entries 1..PROD_W reduce
	// the product mod D one bit per stage, the first ROW_W also reduce
	// the absolute row mod wavelength.
	logic              md_v_s    [0:PROD_W];
	logic [ROW_W-1:0]  md_row_s  [0:PROD_W];
	logic              md_off_s  [0:PROD_W];
	logic [PROD_W-1:0] md_prod_s [0:PROD_W];
	logic [DALL_W-1:0] md_remb_s [0:PROD_W];
	logic [WL_W-1:0]   md_rema_s [0:PROD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_v_s[0] <= 1'b0;
		end else if (adv) begin
			md_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			md_row_s[0]  <= ROW_W'(clip_top_q) + ROW_W'(row_s1);
			md_off_s[0]  <= ({1'b0, row_s1} >= clip_height_q);
			md_prod_s[0] <= PROD_W'(tm_s1) * PROD_W'(half_h);
			md_remb_s[0] <= '0;
			md_rema_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= PROD_W; i++) begin : g_mod
		logic [DALL_W:0] tb;
		logic            geb;

		assign tb  = {md_remb_s[i-1], md_prod_s[i-1][PROD_W-i]};
		assign geb = (tb >= {1'b0, d_all_q});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_v_s[i] <= 1'b0;
			end else if (adv) begin
				md_v_s[i] <= md_v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				md_row_s[i]  <= md_row_s[i-1];
				md_off_s[i]  <= md_off_s[i-1];
				md_prod_s[i] <= md_prod_s[i-1];
				md_remb_s[i] <= geb ? DALL_W'(tb - {1'b0, d_all_q}) : tb[DALL_W-1:0];
			end
		end

		if (i <= ROW_W) begin : g_row
			logic [WL_W:0] ta;
			logic          gea;

			assign ta  = {md_rema_s[i-1], md_row_s[i-1][ROW_W-i]};
			assign gea = (ta >= {1'b0, w_eff});

			always_ff @(posedge clk) begin
				if (adv) begin
					md_rema_s[i] <= gea ? WL_W'(ta - {1'b0, w_eff}) : ta[WL_W-1:0];
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (adv) begin
					md_rema_s[i] <= md_rema_s[i-1];
				end
			end
		end
	end

	// ---------------- stage 3: row term times period ----------------
	logic              v_s3;
	logic [ROW_W-1:0]  row_s3;
	logic              off_s3;
	logic [DALL_W-1:0] amul_s3;
	logic [DALL_W-1:0] b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= md_v_s[PROD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s3  <= md_row_s[PROD_W];
			off_s3  <= md_off_s[PROD_W];
			amul_s3 <= DALL_W'(p_eff) * DALL_W'(md_rema_s[PROD_W]);
			b_s3    <= md_remb_s[PROD_W];
		end
	end

	// ---------------- phase division ----------------
	// entry 0 holds the residue r in [0,D); each later entry yields one
	// more bit of floor(r * 2^n / D).
	logic              ph_v_s   [0:PH_W];
	logic [ROW_W-1:0]  ph_row_s [0:PH_W];
	logic              ph_off_s [0:PH_W];
	logic [DALL_W-1:0] ph_rem_s [0:PH_W];
	logic [PH_W-1:0]   ph_q_s   [0:PH_W];

	logic [DALL_W:0]   r_diff;

	assign r_diff = {1'b0, amul_s3} - {1'b0, b_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_v_s[0] <= 1'b0;
		end else if (adv) begin
			ph_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_row_s[0] <= row_s3;
			ph_off_s[0] <= off_s3;
			ph_rem_s[0] <= (amul_s3 >= b_s3) ? r_diff[DALL_W-1:0] :
				DALL_W'(r_diff + {1'b0, d_all_q});
			ph_q_s[0]   <= '0;
		end
	end

	for (genvar i = 1; i <= PH_W; i++) begin : g_div
		logic [DALL_W:0] tp;
		logic            gep;

		assign tp  = {ph_rem_s[i-1], 1'b0};
		assign gep = (tp >= {1'b0, d_all_q});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ph_v_s[i] <= 1'b0;
			end else if (adv) begin
				ph_v_s[i] <= ph_v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ph_row_s[i] <= ph_row_s[i-1];
				ph_off_s[i] <= ph_off_s[i-1];
				ph_rem_s[i] <= gep ? DALL_W'(tp - {1'b0, d_all_q}) : tp[DALL_W-1:0];
				ph_q_s[i]   <= {ph_q_s[i-1][PH_W-2:0], gep};
			end
		end
	end

	// ---------------- stage 5: quadrant fold ----------------
	logic              v_s5;
	logic [ROW_W-1:0]  row_s5;
	logic              off_s5;
	logic              neg_s5;
	logic [IDX_W-1:0]  idx_s5;
	logic [K_W-1:0]    k_pos;

	assign k_pos = ph_q_s[PH_W][K_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= ph_v_s[PH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s5 <= ph_row_s[PH_W];
			off_s5 <= ph_off_s[PH_W];
			neg_s5 <= ph_q_s[PH_W][PH_W-1];
			// odd quadrants run the table backward
			idx_s5 <= ph_q_s[PH_W][PH_W-2] ?
				IDX_W'(srrs_pkg::QTR) - IDX_W'(k_pos) : IDX_W'(k_pos);
		end
	end

	// ---------------- stage 6: table read ----------------
	logic              v_s6;
	logic [ROW_W-1:0]  row_s6;
	logic              off_s6;
	logic              neg_s6;
	logic [TAB_W-1:0]  tv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s6 <= row_s5;
			off_s6 <= off_s5;
			neg_s6 <= neg_s5;
			tv_s6  <= srrs_pkg::SINE_TAB[idx_s5];
		end
	end

	// ---------------- stage 7: amplitude scale ----------------
	logic              v_s7;
	logic [ROW_W-1:0]  row_s7;
	logic              off_s7;
	logic              neg_s7;
	logic [AMP_W-1:0]  mag_s7;
	logic [MUL_W-1:0]  scaled;

	assign scaled = MUL_W'(tv_s6) * MUL_W'(amplitude_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s7 <= row_s6;
			off_s7 <= off_s6;
			neg_s7 <= neg_s6;
			mag_s7 <= scaled[MUL_W-1:srrs_pkg::TAB_FRAC];
		end
	end

	// ---------------- output register ----------------
	logic             neg_f;
	logic [OUT_W-1:0] mag_x;
	logic [OUT_W-1:0] left_x;

	assign neg_f  = neg_s7 && (mag_s7 != '0);
	assign mag_x  = OUT_W'(mag_s7);
	assign left_x = OUT_W'(clip_left_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shift         <= neg_f ? OUT_W'(-mag_x) : mag_x;
			source_column <= neg_f ? OUT_W'(left_x + mag_x) : left_x;
			dest_column   <= neg_f ? left_x : OUT_W'(left_x + mag_x);
			copy_count    <= (off_s7 || (width_sat <= mag_x)) ? '0 :
				OUT_W'(width_sat - mag_x);
			image_row     <= row_s7;
		end
	end

`ifndef ASSERT_OFF
	a_mod_rem: assert property (@(posedge clk) disable iff (!arst_n)
		md_v_s[PROD_W] |-> (md_remb_s[PROD_W] < d_all_q) && (md_rema_s[PROD_W] < w_eff))
		else $error("remainder chain left a value at or above its modulus");

	a_phase_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ph_v_s[0] |-> (ph_rem_s[0] < d_all_q))
		else $error("phase residue out of range");

	a_tab_idx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (idx_s5 <= IDX_W'(srrs_pkg::QTR)))
		else $error("sine table index beyond quarter wave");

	a_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (source_column == left_x) || (dest_column == left_x))
		else $error("neither column starts at clip_left");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (copy_count <= OUT_W'(srrs_pkg::MAX_IMAGE_DIM)))
		else $error("copy count exceeds maximum width");
`endif

endmodule
`default_nettype wire
